// File: design/cne_pkg.sv
// Package: shared types, constants and a helper function for the compact number encoder.
package cne_pkg;

    localparam int NUM_TAGS = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_BYTES = 9;

    // Register indexes
    localparam logic [2:0] REG_TAG_ZERO     = 3'd0;
    localparam logic [2:0] REG_TAG_ONE      = 3'd1;
    localparam logic [2:0] REG_TAG_INTEGER  = 3'd2;
    localparam logic [2:0] REG_TAG_HALF     = 3'd3;
    localparam logic [2:0] REG_TAG_SINGLE   = 3'd4;
    localparam logic [2:0] REG_TAG_DOUBLE   = 3'd5;

    // One classified request: a byte run of up to nine bytes
    typedef struct packed {
        logic [71:0] bytes;
        logic [3:0]  count;
    } t_run;

    typedef struct packed {
        logic [7:0] zero;
        logic [7:0] one;
        logic [7:0] integ;
        logic [7:0] half;
        logic [7:0] single;
        logic [7:0] dbl;
    } t_tags;

    // Count of magnitude bytes after the lead byte
    function automatic logic [2:0] follow_count(input logic [31:0] mag);
        logic [27:0] s;
        s = mag[31:4];
        if (s == 28'd0) return 3'd0;
        else if (s[27:8] == 20'd0) return 3'd1;
        else if (s[27:16] == 12'd0) return 3'd2;
        else if (s[27:24] == 4'd0) return 3'd3;
        else return 3'd4;
    endfunction

endpackage

// File: design/cne_front.sv
// Front end: classifies one request and builds its byte run.
module cne_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_func,
    input  logic signed [31:0]  i_int_value,
    input  logic [63:0]         i_real_bits,
    input  logic                i_is_double,
    input  cne_pkg::t_tags      i_tags,
    output logic                o_valid,
    output cne_pkg::t_run       o_run
);

    // Stage 1 registers: decoded fields
    logic        r_v1;
    logic        r_func;
    logic [31:0] r_int;
    logic [63:0] r_bits;
    logic        r_dbl;
    logic [31:0] r_fbits;
    logic        r_exact;
    logic        r_iok;
    logic [31:0] r_iraw;
    logic        r_hok;
    logic [31:0] r_hraw;
    logic        r_zero;
    logic        r_one;

    logic [31:0] n_fbits;
    logic        n_exact;
    logic        n_iok, n_hok;
    logic [31:0] n_iraw, n_hraw;

    // Narrow double to float32, and test the integer forms
    always_comb begin
        logic        sgn;
        logic [10:0] e;
        logic [51:0] m;
        logic [52:0] sig;
        logic signed [12:0] ex;
        logic [5:0]  s;
        logic [31:0] base;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] half;
        logic [63:0] msk;
        logic signed [12:0] ue;
        logic [52:0] ival;
        logic [52:0] fmask;
        logic [5:0]  fsh;
        logic [31:0] mag;
        sgn = i_real_bits[63];
        e = i_real_bits[62:52];
        m = i_real_bits[51:0];
        n_fbits = 32'd0;
        n_exact = 1'b0;
        sig = (e == 11'd0) ? {1'b0, m} : {1'b1, m};
        ex = (e == 11'd0) ? -13'sd1022 : $signed({2'b00, e}) - 13'sd1023;
        s = 6'd0;
        base = 32'd0;
        q = 64'd0;
        r = 64'd0;
        half = 64'd0;
        msk = 64'd0;
        if (e == 11'h7ff) begin
            n_exact = (m == 52'd0);
            n_fbits = (m == 52'd0) ? {sgn, 31'h7f800000}
                                   : {sgn, 31'h7fc00000} | {9'd0, m[51:29]};
        end else if (sig == 53'd0) begin
            n_exact = 1'b1;
            n_fbits = {sgn, 31'd0};
        end else if (ex > 13'sd127) begin
            n_fbits = {sgn, 31'h7f800000};
        end else if (ex < -13'sd151) begin
            n_fbits = {sgn, 31'd0};
        end else begin
            if (ex >= -13'sd126) begin
                s = 6'd29;
                base = {6'd0, 8'(ex + 13'sd126), 18'd0} << 5;
            end else begin
                s = 6'(-ex - 13'sd97);
            end
            q = 64'(sig) >> s;
            msk = (64'd1 << s) - 64'd1;
            r = 64'(sig) & msk;
            half = 64'd1 << (s - 6'd1);
            if (r > half || (r == half && q[0])) q = q + 64'd1;
            n_exact = (r == 64'd0);
            n_fbits = {sgn, 31'd0} | (base + q[31:0]);
        end
        // Integer test: value and twice value
        n_iok = 1'b0;
        n_hok = 1'b0;
        n_iraw = 32'd0;
        n_hraw = 32'd0;
        ue = $signed({2'b00, e}) - 13'sd1023;
        ival = 53'd0;
        fmask = 53'd0;
        fsh = 6'd0;
        mag = 32'd0;
        if (e != 11'h7ff && e != 11'd0 && ue <= 13'sd31) begin
            // value * 1
            if (ue >= 13'sd0) begin
                fsh = 6'(13'sd52 - ue);
                fmask = (53'd1 << fsh) - 53'd1;
                if ((sig & fmask) == 53'd0) begin
                    ival = sig >> fsh;
                    mag = ival[31:0];
                    if (ue <= 13'sd30 || (sgn && m == 52'd0)) begin
                        n_iok = 1'b1;
                        n_iraw = sgn ? (32'd0 - mag) : mag;
                    end
                end
            end
            // value * 2
            if (ue >= -13'sd1 && ue <= 13'sd30) begin
                fsh = 6'(13'sd51 - ue);
                fmask = (53'd1 << fsh) - 53'd1;
                if ((sig & fmask) == 53'd0) begin
                    ival = sig >> fsh;
                    mag = ival[31:0];
                    if (ue <= 13'sd29 || (sgn && m == 52'd0)) begin
                        n_hok = 1'b1;
                        n_hraw = sgn ? (32'd0 - mag) : mag;
                    end
                end
            end
        end
    end

    // Capture stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_func  <= i_func;
        r_int   <= i_int_value;
        r_bits  <= i_real_bits;
        r_dbl   <= i_is_double;
        r_fbits <= n_fbits;
        r_exact <= n_exact;
        r_iok   <= n_iok;
        r_iraw  <= n_iraw;
        r_hok   <= n_hok;
        r_hraw  <= n_hraw;
        r_zero  <= (i_real_bits[62:0] == 63'd0);
        r_one   <= (i_real_bits == 64'h3ff0000000000000);
    end

    // Integer code of one raw value: lead byte plus up to four bytes
    function automatic cne_pkg::t_run int_code(input logic [31:0] raw);
        cne_pkg::t_run rr;
        logic [31:0] mag;
        logic [2:0]  cnt;
        mag = raw[31] ? (32'd0 - raw) : raw;
        cnt = cne_pkg::follow_count(mag);
        rr.bytes = {36'd0, mag[31:4], ~raw[31], cnt, mag[3:0]};
        rr.bytes = rr.bytes & ((72'd1 << (8 * (32'(cnt) + 1))) - 72'd1);
        rr.count = 4'(cnt) + 4'd1;
        return rr;
    endfunction

    // Choose the form and lay out the bytes
    always_comb begin
        cne_pkg::t_run ic;
        cne_pkg::t_run hc;
        logic [3:0] rbytes;
        ic = int_code(r_iraw);
        hc = int_code(r_hraw);
        rbytes = (r_dbl && !r_exact) ? 4'd8 : 4'd4;
        if (!r_func) begin
            o_run = int_code(r_int);
        end else if (r_zero) begin
            o_run = '{bytes: {64'd0, i_tags.zero}, count: 4'd1};
        end else if (r_one) begin
            o_run = '{bytes: {64'd0, i_tags.one}, count: 4'd1};
        end else if (r_iok && ic.count < rbytes) begin
            o_run = '{bytes: {ic.bytes[63:0], i_tags.integ}, count: ic.count + 4'd1};
        end else if (r_hok && hc.count < rbytes) begin
            o_run = '{bytes: {hc.bytes[63:0], i_tags.half}, count: hc.count + 4'd1};
        end else if (rbytes == 4'd4) begin
            o_run = '{bytes: {32'd0, r_fbits, i_tags.single}, count: 4'd5};
        end else begin
            o_run = '{bytes: {r_bits, i_tags.dbl}, count: 4'd9};
        end
    end

    assign o_valid = r_v1;

endmodule

// File: design/cne_back.sv
// Back end: run queue and byte serializer.
module cne_back #(
    parameter int DEPTH = cne_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cne_pkg::t_run  i_run,
    output logic           o_full,
    output logic           o_strobe,
    output logic [7:0]     o_out_byte,
    output logic           o_last_byte
);

    localparam int AW = $clog2(DEPTH);

    cne_pkg::t_run r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic [3:0]    r_idx;
    logic          pop;
    logic [AW:0]   n_cnt;
    cne_pkg::t_run cur;

    assign cur = r_mem[r_rp];
    assign pop = (r_cnt != '0) && (r_idx == cur.count - 4'd1);
    assign n_cnt = r_cnt + (AW+1)'(i_valid) - (AW+1)'(pop);
    // Leave room for two runs already in the front pipeline
    assign o_full = (r_cnt >= (AW+1)'(DEPTH - 2));

    // Store runs
    always_ff @(posedge i_clk) begin
        if (i_valid) r_mem[r_wp] <= i_run;
    end

    // Advance pointers and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_idx <= 4'd0;
        end else begin
            if (i_valid) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
                r_idx <= 4'd0;
            end else if (r_cnt != '0) begin
                r_idx <= r_idx + 4'd1;
            end
            r_cnt <= n_cnt;
        end
    end

    // Register output byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= (r_cnt != '0);
        end
        o_out_byte  <= cur.bytes[8*r_idx +: 8];
        o_last_byte <= pop;
    end

endmodule

// File: design/compact_number_encoder.sv
// Top level: compact number encoder with APB tag registers.
// A request passes the front-end stage 1 registers, the run queue and the output byte register before its first byte.
// Throughput: one byte per cycle while the run queue holds a run; a request's run is 1 to 9 bytes,
// sent by the byte serializer; busy rises while the run queue is nearly full.
// Reset (synchronous, active low) empties the queue and loads the default tags.
// Results are strobed for one cycle each; the receiver cannot stall them.
module compact_number_encoder #(
    parameter int QUEUE_DEPTH = cne_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_func,
    input  logic signed [31:0]  i_int_value,
    input  logic [63:0]         i_real_bits,
    input  logic                i_is_double,
    output logic                o_strobe,
    output logic [7:0]          o_out_byte,
    output logic                o_last_byte,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cne_pkg::t_tags r_tags;
    cne_pkg::t_run  run;
    logic           fr_valid;
    logic           full;

    assign pready = 1'b1;
    assign busy = full;

    // Write tag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tags <= '{zero: 8'd0, one: 8'd1, integ: 8'd2, half: 8'd3,
                        single: 8'd4, dbl: 8'd5};
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:2])
                cne_pkg::REG_TAG_ZERO:    r_tags.zero   <= pwdata[7:0];
                cne_pkg::REG_TAG_ONE:     r_tags.one    <= pwdata[7:0];
                cne_pkg::REG_TAG_INTEGER: r_tags.integ  <= pwdata[7:0];
                cne_pkg::REG_TAG_HALF:    r_tags.half   <= pwdata[7:0];
                cne_pkg::REG_TAG_SINGLE:  r_tags.single <= pwdata[7:0];
                cne_pkg::REG_TAG_DOUBLE:  r_tags.dbl    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read tag registers
    always_comb begin
        unique case (paddr[4:2])
            cne_pkg::REG_TAG_ZERO:    prdata = {24'd0, r_tags.zero};
            cne_pkg::REG_TAG_ONE:     prdata = {24'd0, r_tags.one};
            cne_pkg::REG_TAG_INTEGER: prdata = {24'd0, r_tags.integ};
            cne_pkg::REG_TAG_HALF:    prdata = {24'd0, r_tags.half};
            cne_pkg::REG_TAG_SINGLE:  prdata = {24'd0, r_tags.single};
            cne_pkg::REG_TAG_DOUBLE:  prdata = {24'd0, r_tags.dbl};
            default:                  prdata = 32'd0;
        endcase
    end

    cne_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_func      (i_func),
        .i_int_value (i_int_value),
        .i_real_bits (i_real_bits),
        .i_is_double (i_is_double),
        .i_tags      (r_tags),
        .o_valid     (fr_valid),
        .o_run       (run)
    );

    cne_back #(.DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (fr_valid),
        .i_run       (run),
        .o_full      (full),
        .o_strobe    (o_strobe),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

// File: sim/testbench.sv
// Testbench for compact_number_encoder: directed and random requests checked against a predictor.
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_exp_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic signed [31:0] i_int_value;
    logic [63:0] i_real_bits;
    logic        i_is_double;
    logic        o_strobe;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0]  tag_reg [cne_pkg::NUM_TAGS];
    t_exp_byte   pending_bytes [$];
    int          error_count;
    int          cycle_count;
    int          gap_pct;

    compact_number_encoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_func     (i_func),
        .i_int_value(i_int_value),
        .i_real_bits(i_real_bits),
        .i_is_double(i_is_double),
        .o_strobe   (o_strobe),
        .o_out_byte (o_out_byte),
        .o_last_byte(o_last_byte),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Generate the clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** compact_number_encoder: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Check each strobed byte against the oldest expected one
    always @(posedge i_clk) begin
        t_exp_byte want;
        if (i_rst_n && o_strobe) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", o_out_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch($sformatf("byte %02h, want %02h", o_out_byte, want.data));
                if (o_last_byte !== want.last)
                    report_mismatch($sformatf("last mark %b, want %b", o_last_byte, want.last));
            end
        end
    end

    // Bytes needed for magnitude>>4
    function automatic int extra_bytes(input logic [31:0] mag);
        logic [27:0] rest;
        rest = mag[31:4];
        if (rest == 0) return 0;
        if (rest < 28'h100) return 1;
        if (rest < 28'h10000) return 2;
        if (rest < 28'h1000000) return 3;
        return 4;
    endfunction

    function automatic logic [31:0] abs_of(input logic [31:0] raw);
        return raw[31] ? (32'd0 - raw) : raw;
    endfunction

    // Append the sign/length-prefixed integer code
    function automatic void emit_int(inout logic [7:0] run [$], input logic [31:0] raw);
        logic [31:0] mag;
        logic [31:0] rest;
        int          cnt;
        mag = abs_of(raw);
        cnt = extra_bytes(mag);
        rest = mag >> 4;
        run.push_back({~raw[31], cnt[2:0], mag[3:0]});
        for (int k = 0; k < cnt; k++) begin
            run.push_back(rest[7:0]);
            rest = rest >> 8;
        end
    endfunction

    // Round a double to float32 bits, nearest-even; flag whether nothing was lost
    function automatic logic [31:0] to_single(input logic [63:0] b, output bit exact);
        logic [31:0] sgn;
        logic [10:0] e;
        logic [51:0] m;
        logic [63:0] sig, q, r, half;
        int          ex, s;
        logic [31:0] base;
        sgn = {b[63], 31'd0};
        e = b[62:52];
        m = b[51:0];
        if (e == 11'h7ff) begin
            exact = (m == 0);
            if (m == 0) return sgn | 32'h7f800000;
            return sgn | 32'h7fc00000 | {9'd0, m[51:29]};
        end
        if (e == 0) begin
            sig = {12'd0, m};
            ex = -1022;
        end else begin
            sig = {11'd0, 1'b1, m};
            ex = int'(e) - 1023;
        end
        exact = 1'b1;
        if (sig == 0) return sgn;
        exact = 1'b0;
        if (ex > 127) return sgn | 32'h7f800000;
        if (ex >= -126) begin
            s = 29;
            base = 32'((ex + 126) << 23);
        end else begin
            s = -ex - 97;
            base = 32'd0;
        end
        if (s >= 55) return sgn;
        q = sig >> s;
        r = sig & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 1);
        if (r > half || (r == half && q[0])) q = q + 64'd1;
        exact = (r == 0);
        return sgn | (base + q[31:0]);
    endfunction

    // Integral value within int32
    function automatic bit as_int32(input real v, output logic [31:0] raw);
        int iv;
        raw = 32'd0;
        if (v >= -2147483648.0 && v <= 2147483647.0) begin
            iv = $rtoi(v);
            if ($itor(iv) == v) begin
                raw = iv;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Work out the byte run for one request and queue it
    function automatic void predict_run(input logic func, input logic [31:0] ival,
                                        input logic [63:0] bits, input logic dbl);
        logic [7:0]  run [$];
        logic [31:0] fbits, raw;
        bit          exact;
        int          width;
        real         v;
        t_exp_byte   eb;
        if (!func) begin
            emit_int(run, ival);
        end else begin
            v = $bitstoreal(bits);
            if (v == 0.0) begin
                run.push_back(tag_reg[cne_pkg::REG_TAG_ZERO]);
            end else if (v == 1.0) begin
                run.push_back(tag_reg[cne_pkg::REG_TAG_ONE]);
            end else begin
                fbits = to_single(bits, exact);
                width = (dbl && !exact) ? 8 : 4;
                if (as_int32(v, raw) && extra_bytes(abs_of(raw)) + 1 < width) begin
                    run.push_back(tag_reg[cne_pkg::REG_TAG_INTEGER]);
                    emit_int(run, raw);
                end else if (as_int32(v * 2.0, raw) && extra_bytes(abs_of(raw)) + 1 < width) begin
                    run.push_back(tag_reg[cne_pkg::REG_TAG_HALF]);
                    emit_int(run, raw);
                end else if (width == 4) begin
                    run.push_back(tag_reg[cne_pkg::REG_TAG_SINGLE]);
                    for (int k = 0; k < 4; k++) run.push_back(fbits[8*k +: 8]);
                end else begin
                    run.push_back(tag_reg[cne_pkg::REG_TAG_DOUBLE]);
                    for (int k = 0; k < 8; k++) run.push_back(bits[8*k +: 8]);
                end
            end
        end
        foreach (run[k]) begin
            eb.data = run[k];
            eb.last = (k == run.size() - 1);
            pending_bytes.push_back(eb);
        end
    endfunction

    // Send one request, then idle at random per the current gap rate
    task automatic send_request(input logic func, input logic [31:0] ival,
                                input logic [63:0] bits, input logic dbl);
        @(negedge i_clk);
        i_func = func;
        i_int_value = ival;
        i_real_bits = bits;
        i_is_double = dbl;
        start = 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_run(func, ival, bits, dbl);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            i_func = 1'($urandom);
            i_int_value = $urandom;
        end
    endtask

    task automatic send_int(input logic [31:0] ival);
        send_request(1'b0, ival, {$urandom, $urandom}, 1'($urandom));
    endtask

    task automatic send_real(input real v, input logic dbl);
        send_request(1'b1, $urandom, $realtobits(v), dbl);
    endtask

    // Hold until every expected byte is out, plus the pipeline depth
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup then access
    task automatic write_reg(input int idx, input logic [7:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 5'(idx * 4);
        pwdata = {8'($urandom_range(255)), 16'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx < cne_pkg::NUM_TAGS) tag_reg[idx] = value;
    endtask

    task automatic load_tags(input logic [7:0] t0, t1, t2, t3, t4, t5);
        wait_drained();
        write_reg(cne_pkg::REG_TAG_ZERO, t0);
        write_reg(cne_pkg::REG_TAG_ONE, t1);
        write_reg(cne_pkg::REG_TAG_INTEGER, t2);
        write_reg(cne_pkg::REG_TAG_HALF, t3);
        write_reg(cne_pkg::REG_TAG_SINGLE, t4);
        write_reg(cne_pkg::REG_TAG_DOUBLE, t5);
    endtask

    function automatic real half_of(input int v);
        return $itor(v) + 0.5;
    endfunction

    // Integer extremes and byte-count boundaries
    task automatic test_integers();
        send_int(32'd0);
        send_int(32'd15);
        send_int(32'd16);
        send_int(-32'sd1);
        send_int(-32'sd16);
        send_int(32'h00000fff);
        send_int(32'h7fffffff);
        send_int(32'h80000000);
        send_int(32'h80000001);
    endtask

    // Each real form and the narrowing corner cases
    task automatic test_reals();
        send_real(0.0, 1'b1);
        send_request(1'b1, 0, 64'h8000000000000000, 1'b0);
        send_real(1.0, 1'b1);
        send_real(-1.0, 1'b0);
        send_real(-3.5, 1'b1);
        send_real(100000.5, 1'b1);
        send_real(0.1, 1'b1);
        send_real(0.1, 1'b0);
        send_real(1.0e20, 1'b1);
        send_real(-2147483648.0, 1'b1);
        send_request(1'b1, 0, 64'h7ff0000000000000, 1'b1);
        send_request(1'b1, 0, 64'hfff0000000000000, 1'b0);
        send_request(1'b1, 0, 64'h7ff8000123456789, 1'b1);
        send_request(1'b1, 0, 64'hfff4000123456789, 1'b0);
        send_request(1'b1, 0, 64'h0000000000000001, 1'b1);
        send_request(1'b1, 0, 64'h3730000000000000, 1'b1);
        send_real(1.0e39, 1'b1);
        send_real(1.0e39, 1'b0);
        send_request(1'b1, 0, 64'h36a0000000000001, 1'b0);
    endtask

    // One random request: mostly well-formed values that hit each form
    task automatic send_random();
        logic [63:0] bits;
        logic [31:0] iv;
        iv = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) iv = -iv;
        case ($urandom_range(7)) inside
            0, 1: begin
                send_int(iv);
                return;
            end
            2: bits = {$urandom, $urandom};
            3: bits = $realtobits($itor($signed(iv)));
            4: bits = $realtobits(half_of($signed(iv) >>> 1));
            5: bits = {1'($urandom_range(1)), 11'(1023 - 150 + $urandom_range(300)),
                       23'($urandom), 29'd0};
            6: bits = {1'($urandom_range(1)), 11'($urandom_range(2047)), 20'($urandom),
                       $urandom};
            default: begin
                case ($urandom_range(4))
                    0: bits = 64'h0;
                    1: bits = $realtobits(1.0);
                    2: bits = {1'($urandom_range(1)), 11'h7ff, 52'd0};
                    3: bits = {1'($urandom_range(1)), 11'h7ff, 20'($urandom) | 20'h1,
                               $urandom};
                    default: bits = {1'($urandom_range(1)), 11'd0, 20'($urandom), $urandom};
                endcase
            end
        endcase
        send_request(1'b1, $urandom, bits, 1'($urandom_range(1)));
    endtask

    task automatic test_random(input int count, input int pct);
        gap_pct = pct;
        repeat (count) send_random();
        gap_pct = 0;
    endtask

    // Tag registers at their extremes and random values, with bad indexes ignored
    task automatic test_tag_settings();
        load_tags(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        test_reals();
        load_tags(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
        write_reg(6, 8'h5a);
        write_reg(7, 8'ha5);
        test_random(10, 47);
        load_tags(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        test_random(8, 11);
        load_tags(8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = 1'b0;
        i_int_value = 0;
        i_real_bits = 0;
        i_is_double = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 5'd0;
        pwdata = 32'd0;
        error_count = 0;
        cycle_count = 0;
        gap_pct = 0;
        for (int k = 0; k < cne_pkg::NUM_TAGS; k++) tag_reg[k] = 8'(k);
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_integers();
        test_reals();
        test_tag_settings();
        test_random(20, 0);
        wait_drained();
        test_random(15, 47);
        test_random(10, 11);

        wait_drained();
        if (error_count == 0) begin
            $display("** compact_number_encoder: PASSED **");
        end else begin
            $display("** compact_number_encoder: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/cne_pkg.sv
design/cne_front.sv
design/cne_back.sv
design/compact_number_encoder.sv
sim/testbench.sv
